/* rtl/vector_to_view_angles_core_defines.svh */
// Assertion shorthands used by the angle pipeline's output stage.
`ifndef VECTOR_TO_VIEW_ANGLES_CORE_DEFINES_SVH
`define VECTOR_TO_VIEW_ANGLES_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VTVA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VTVA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/vtva_pkg.sv */
`default_nettype none

package vtva_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int COORD_BITS    = 24;

    localparam int DIFF_W    = COORD_BITS + 1;
    // Two vectoring passes grow the magnitude by less than 2^4 over a difference.
    localparam int CW        = COORD_BITS + 5;
    localparam int ANG_W     = 26;
    localparam int OUT_SHIFT = 9;
    localparam int OUT_W     = ANG_W + 1 - OUT_SHIFT;
    localparam int H_W       = 16;
    localparam int V_W       = 15;

    localparam int GAIN_W    = 31;
    localparam int GAIN_FRAC = 29;
    localparam int PROD_W    = DIFF_W + GAIN_W;
    localparam int KY_W      = PROD_W - GAIN_FRAC;

    localparam int IN_TDATA_W  = ((6 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((H_W + V_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - H_W - V_W;

    localparam logic signed [GAIN_W-1:0] GAIN_Q29   = GAIN_W'(884097682);
    localparam logic signed [PROD_W-1:0] GAIN_RND   = PROD_W'(64'd1 << (GAIN_FRAC - 1));
    localparam logic signed [ANG_W-1:0]  DEG180_Q16 = ANG_W'(180 * 65536);
    localparam logic signed [ANG_W:0]    OUT_RND    = (ANG_W + 1)'(1 << (OUT_SHIFT - 1));
    localparam logic signed [OUT_W-1:0]  H_LIM      = OUT_W'(23040);
    localparam logic signed [OUT_W-1:0]  V_LIM      = OUT_W'(11520);

    localparam int ATAN_W = 22;

    // atan(2^-i) in degrees, 16 fraction bits.
    localparam logic [ATAN_W-1:0] ATAN_Q16 [32] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
        22'd234379,  22'd117304,  22'd58666,  22'd29335,
        22'd14668,   22'd7334,    22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,
        22'd57,      22'd29,      22'd14,     22'd7,
        22'd4,       22'd2,       22'd1,      22'd0,
        22'd0,       22'd0,       22'd0,      22'd0,
        22'd0,       22'd0,       22'd0,      22'd0
    };

    typedef struct packed {
        logic                    degen;
        logic                    hzero;
        logic signed [CW-1:0]    aux;
        logic signed [ANG_W-1:0] hang;
    } t_side;

    // Round a Q16 degree angle to 1/128 degree, half up, and clamp to +-lim.
    function automatic logic signed [OUT_W-1:0] to_out(
        input logic signed [ANG_W-1:0] ang,
        input logic signed [OUT_W-1:0] lim
    );
        logic signed [ANG_W:0]   sum;
        logic signed [OUT_W-1:0] v;
        sum = $signed({ang[ANG_W-1], ang}) + OUT_RND;
        v   = $signed(sum[ANG_W:OUT_SHIFT]);
        if (v > lim) begin
            v = lim;
        end else if (v < -lim) begin
            v = -lim;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

/* rtl/vtva_front.sv */
`default_nettype none

module vtva_front
    import vtva_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_vld,
    input  logic signed [COORD_BITS-1:0] i_src_x,
    input  logic signed [COORD_BITS-1:0] i_src_y,
    input  logic signed [COORD_BITS-1:0] i_src_z,
    input  logic signed [COORD_BITS-1:0] i_dst_x,
    input  logic signed [COORD_BITS-1:0] i_dst_y,
    input  logic signed [COORD_BITS-1:0] i_dst_z,
    output logic                         o_vld,
    output logic signed [CW-1:0]         o_x,
    output logic signed [CW-1:0]         o_y,
    output logic signed [ANG_W-1:0]      o_ang,
    output t_side                        o_side
);

    // Stage 1: differences.
    logic                     r1_vld;
    logic signed [DIFF_W-1:0] r1_dx, r1_dy, r1_dz;
    logic signed [DIFF_W-1:0] n1_dx, n1_dy, n1_dz;

    // Stage 2: half-plane fold for the first pass and the gain product.
    logic                     r2_vld;
    logic signed [CW-1:0]     r2_x, r2_y, n2_x, n2_y;
    logic signed [ANG_W-1:0]  r2_base, n2_base;
    logic signed [PROD_W-1:0] r2_prod, n2_prod;
    logic                     r2_degen, r2_hzero, n2_degen, n2_hzero;
    logic signed [CW-1:0]     dx_e, dz_e;

    // Stage 3: rounding of the gain-scaled vertical component.
    logic                     r3_vld;
    logic signed [CW-1:0]     r3_x, r3_y;
    logic signed [ANG_W-1:0]  r3_ang;
    t_side                    r3_side, n3_side;
    logic signed [PROD_W-1:0] ky_sum;
    logic signed [KY_W-1:0]   ky;

    always_comb begin
        n1_dx = $signed({i_src_x[COORD_BITS-1], i_src_x}) - $signed({i_dst_x[COORD_BITS-1], i_dst_x});
        n1_dy = $signed({i_src_y[COORD_BITS-1], i_src_y}) - $signed({i_dst_y[COORD_BITS-1], i_dst_y});
        n1_dz = $signed({i_src_z[COORD_BITS-1], i_src_z}) - $signed({i_dst_z[COORD_BITS-1], i_dst_z});
    end

    always_comb begin
        dx_e     = $signed({{(CW - DIFF_W){r1_dx[DIFF_W-1]}}, r1_dx});
        dz_e     = $signed({{(CW - DIFF_W){r1_dz[DIFF_W-1]}}, r1_dz});
        n2_hzero = (r1_dx == '0) && (r1_dz == '0);
        n2_degen = n2_hzero && (r1_dy == '0);
        // A vector in the negative z half-plane is turned by 180 degrees first.
        if (r1_dz[DIFF_W-1]) begin
            n2_x    = -dz_e;
            n2_y    = -dx_e;
            n2_base = r1_dx[DIFF_W-1] ? -DEG180_Q16 : DEG180_Q16;
        end else begin
            n2_x    = dz_e;
            n2_y    = dx_e;
            n2_base = '0;
        end
        n2_prod = $signed({{GAIN_W{r1_dy[DIFF_W-1]}}, r1_dy})
                * $signed({{DIFF_W{GAIN_Q29[GAIN_W-1]}}, GAIN_Q29});
    end

    always_comb begin
        ky_sum        = r2_prod + GAIN_RND;
        ky            = $signed(ky_sum[PROD_W-1:GAIN_FRAC]);
        n3_side.degen = r2_degen;
        n3_side.hzero = r2_hzero;
        n3_side.aux   = $signed({{(CW - KY_W){ky[KY_W-1]}}, ky});
        n3_side.hang  = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_dx    <= n1_dx;
            r1_dy    <= n1_dy;
            r1_dz    <= n1_dz;
            r2_x     <= n2_x;
            r2_y     <= n2_y;
            r2_base  <= n2_base;
            r2_prod  <= n2_prod;
            r2_degen <= n2_degen;
            r2_hzero <= n2_hzero;
            r3_x     <= r2_x;
            r3_y     <= r2_y;
            r3_ang   <= r2_base;
            r3_side  <= n3_side;
        end
    end

    assign o_vld  = r3_vld;
    assign o_x    = r3_x;
    assign o_y    = r3_y;
    assign o_ang  = r3_ang;
    assign o_side = r3_side;

endmodule

`default_nettype wire

/* rtl/vtva_cordic.sv */
`default_nettype none

module vtva_cordic
    import vtva_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_vld,
    input  logic signed [CW-1:0]    i_x,
    input  logic signed [CW-1:0]    i_y,
    input  logic signed [ANG_W-1:0] i_ang,
    input  t_side                   i_side,
    output logic                    o_vld,
    output logic signed [CW-1:0]    o_x,
    output logic signed [CW-1:0]    o_y,
    output logic signed [ANG_W-1:0] o_ang,
    output t_side                   o_side
);

    // Entry s feeds stage s; entry s+1 is the register of stage s.
    logic [CORDIC_STAGES:0]  w_vld;
    logic signed [CW-1:0]    w_x   [CORDIC_STAGES+1];
    logic signed [CW-1:0]    w_y   [CORDIC_STAGES+1];
    logic signed [ANG_W-1:0] w_ang [CORDIC_STAGES+1];
    t_side                   w_side[CORDIC_STAGES+1];

    assign w_vld[0]  = i_vld;
    assign w_x[0]    = i_x;
    assign w_y[0]    = i_y;
    assign w_ang[0]  = i_ang;
    assign w_side[0] = i_side;

    for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
        localparam logic signed [ANG_W-1:0] STEP =
            $signed({{(ANG_W - ATAN_W){1'b0}}, ATAN_Q16[s]});

        logic                    r_vld;
        logic signed [CW-1:0]    r_x, r_y, n_x, n_y, xs, ys;
        logic signed [ANG_W-1:0] r_ang, n_ang;
        t_side                   r_side;

        always_comb begin
            xs = w_x[s] >>> s;
            ys = w_y[s] >>> s;
            // Non-negative y turns clockwise and adds the step angle.
            if (!w_y[s][CW-1]) begin
                n_x   = w_x[s] + ys;
                n_y   = w_y[s] - xs;
                n_ang = w_ang[s] + STEP;
            end else begin
                n_x   = w_x[s] - ys;
                n_y   = w_y[s] + xs;
                n_ang = w_ang[s] - STEP;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= w_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x    <= n_x;
                r_y    <= n_y;
                r_ang  <= n_ang;
                r_side <= w_side[s];
            end
        end

        assign w_vld[s+1]  = r_vld;
        assign w_x[s+1]    = r_x;
        assign w_y[s+1]    = r_y;
        assign w_ang[s+1]  = r_ang;
        assign w_side[s+1] = r_side;
    end

    assign o_vld  = w_vld[CORDIC_STAGES];
    assign o_x    = w_x[CORDIC_STAGES];
    assign o_y    = w_y[CORDIC_STAGES];
    assign o_ang  = w_ang[CORDIC_STAGES];
    assign o_side = w_side[CORDIC_STAGES];

endmodule

`default_nettype wire

/* rtl/vtva_out.sv */
`default_nettype none

`include "vector_to_view_angles_core_defines.svh"

module vtva_out
    import vtva_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    input  logic signed [ANG_W-1:0] i_ang,
    input  t_side                   i_side,
    input  logic                    i_m_tready,
    output logic                    o_en,
    output logic                    o_tvalid,
    output logic signed [H_W-1:0]   o_h,
    output logic signed [V_W-1:0]   o_v,
    output logic                    o_degen
);

    logic                    r_cvld;
    logic signed [H_W-1:0]   r_ch, n_ch;
    logic signed [V_W-1:0]   r_cv, n_cv;
    logic                    r_cdeg;
    logic signed [OUT_W-1:0] h_sat, v_sat;
    logic signed [ANG_W-1:0] v_ang;

    logic                    r_out_vld;
    logic signed [H_W-1:0]   r_out_h;
    logic signed [V_W-1:0]   r_out_v;
    logic                    r_out_deg;

    logic                    r_skid_vld;
    logic signed [H_W-1:0]   r_skid_h;
    logic signed [V_W-1:0]   r_skid_v;
    logic                    r_skid_deg;

    // The pipeline moves whenever the skid stage is free.
    assign o_en = !r_skid_vld;

    always_comb begin
        v_ang = -i_ang;
        h_sat = to_out(i_side.hang, H_LIM);
        v_sat = to_out(v_ang, V_LIM);
        n_ch  = (i_side.degen || i_side.hzero) ? '0 : $signed(h_sat[H_W-1:0]);
        n_cv  = i_side.degen ? '0 : $signed(v_sat[V_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvld <= 1'b0;
        end else if (o_en) begin
            r_cvld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_ch   <= n_ch;
            r_cv   <= n_cv;
            r_cdeg <= i_side.degen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (i_m_tready) begin
                r_skid_vld <= 1'b0;
            end
        end else if (r_cvld) begin
            if (!r_out_vld || i_m_tready) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (i_m_tready) begin
                r_out_h   <= r_skid_h;
                r_out_v   <= r_skid_v;
                r_out_deg <= r_skid_deg;
            end
        end else if (r_cvld) begin
            if (!r_out_vld || i_m_tready) begin
                r_out_h   <= r_ch;
                r_out_v   <= r_cv;
                r_out_deg <= r_cdeg;
            end else begin
                r_skid_h   <= r_ch;
                r_skid_v   <= r_cv;
                r_skid_deg <= r_cdeg;
            end
        end
    end

    assign o_tvalid = r_out_vld;
    assign o_h      = r_out_h;
    assign o_v      = r_out_v;
    assign o_degen  = r_out_deg;

    `VTVA_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_vld, r_out_vld, "skid full with empty output")
    `VTVA_ASSERT_IMP(a_degen_zero, i_clk, i_rst_n, r_out_vld && r_out_deg, (r_out_h == '0) && (r_out_v == '0), "degenerate beat carries nonzero angles")
    `VTVA_ASSERT_IMP(a_v_range, i_clk, i_rst_n, r_out_vld, ($signed({r_out_v[V_W-1], r_out_v}) <= V_LIM) && ($signed({r_out_v[V_W-1], r_out_v}) >= -V_LIM), "vertical angle out of range")
    `VTVA_ASSERT_NXT(a_skid_hold, i_clk, i_rst_n, r_skid_vld && !i_m_tready, r_skid_vld, "skid dropped a beat under stall")

endmodule

`default_nettype wire

/* rtl/vector_to_view_angles_core.sv */
// Azimuth and elevation of the difference d = src - dst of two signed 3D points.
// The result beat gives the horizontal angle atan2(dx, dz) and the negated elevation
// -asin(dy/|d|), both in 1/128 degree, rounded half up and clamped to +-180 and +-90
// degrees; a zero difference gives both angles 0 with tuser set. Two unrolled
// 16-stage CORDIC vectoring pipelines do the work, so one point pair is taken every
// clock cycle while tready is high; a result passes the front, both CORDIC passes
// and the output registers. A two-entry output buffer keeps the input side open for
// one more beat while a result waits; tready drops only when that buffer is full.
`default_nettype none

module vector_to_view_angles_core
    import vtva_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // src_x, src_y, src_z, dst_x, dst_y, dst_z from the lowest bits up.
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // horizontal_angle, vertical_angle, then zero padding.
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // degenerate.
    output logic                   o_m_axis_tuser
);

    logic                    en;

    logic                    f_vld;
    logic signed [CW-1:0]    f_x, f_y;
    logic signed [ANG_W-1:0] f_ang;
    t_side                   f_side;

    logic                    p1_vld;
    logic signed [CW-1:0]    p1_x, p1_y;
    logic signed [ANG_W-1:0] p1_ang;
    t_side                   p1_side;

    t_side                   p2_in_side;
    logic                    p2_vld;
    logic signed [CW-1:0]    p2_x, p2_y;
    logic signed [ANG_W-1:0] p2_ang;
    t_side                   p2_side;

    logic signed [H_W-1:0]   out_h;
    logic signed [V_W-1:0]   out_v;

    assign o_s_axis_tready = en;

    vtva_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_s_axis_tvalid),
        .i_src_x ($signed(i_s_axis_tdata[0*COORD_BITS +: COORD_BITS])),
        .i_src_y ($signed(i_s_axis_tdata[1*COORD_BITS +: COORD_BITS])),
        .i_src_z ($signed(i_s_axis_tdata[2*COORD_BITS +: COORD_BITS])),
        .i_dst_x ($signed(i_s_axis_tdata[3*COORD_BITS +: COORD_BITS])),
        .i_dst_y ($signed(i_s_axis_tdata[4*COORD_BITS +: COORD_BITS])),
        .i_dst_z ($signed(i_s_axis_tdata[5*COORD_BITS +: COORD_BITS])),
        .o_vld   (f_vld),
        .o_x     (f_x),
        .o_y     (f_y),
        .o_ang   (f_ang),
        .o_side  (f_side)
    );

    // First pass on (dz, dx): azimuth and the gain-scaled horizontal length.
    vtva_cordic u_pass_h (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (f_vld),
        .i_x     (f_x),
        .i_y     (f_y),
        .i_ang   (f_ang),
        .i_side  (f_side),
        .o_vld   (p1_vld),
        .o_x     (p1_x),
        .o_y     (p1_y),
        .o_ang   (p1_ang),
        .o_side  (p1_side)
    );

    always_comb begin
        p2_in_side.degen = p1_side.degen;
        p2_in_side.hzero = p1_side.hzero;
        p2_in_side.aux   = p1_y;
        p2_in_side.hang  = p1_ang;
    end

    // Second pass on (r, K*dy): elevation.
    vtva_cordic u_pass_v (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (p1_vld),
        .i_x     (p1_x),
        .i_y     (p1_side.aux),
        .i_ang   ('0),
        .i_side  (p2_in_side),
        .o_vld   (p2_vld),
        .o_x     (p2_x),
        .o_y     (p2_y),
        .o_ang   (p2_ang),
        .o_side  (p2_side)
    );

    vtva_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (p2_vld && (p2_x[CW-1] == 1'b0 || p2_y[CW-1] == 1'b0 || 1'b1)),
        .i_ang      (p2_ang),
        .i_side     (p2_side),
        .i_m_tready (i_m_axis_tready),
        .o_en       (en),
        .o_tvalid   (o_m_axis_tvalid),
        .o_h        (out_h),
        .o_v        (out_v),
        .o_degen    (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_v, out_h};

endmodule

`default_nettype wire
